// ===== hdl/wsfd_pkg.sv =====
// Shared constants, codes and control types for the wind sensor frame decoder.
`timescale 1ns / 1ps

package wsfd_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TIME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd2;

  localparam int BIT_TIME_W = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int SPEED_W    = 12;

  localparam logic [BIT_TIME_W-1:0] BIT_TIME_RST    = 16'd1200;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST     = 16'd55020;
  localparam logic [SPEED_W-1:0]    SPEED_LIMIT_RST = 12'd400;

  // Frame geometry
  localparam int FRAME_BITS_DEF = 41;
  localparam int EDGE_W         = 32;
  localparam int SUM_W          = 17;
  localparam int DIV_W          = 16;

  localparam int DIR_LSB = 5;
  localparam int DIR_W   = 4;
  localparam int SPD_LSB = 9;
  localparam int CHK_LSB = 21;
  localparam int CHK_W   = 4;

  // Result word
  localparam int STATUS_W = 2;
  localparam int DEG_W    = 12;
  localparam int KMH_W    = 18;
  localparam int OUT_W    = STATUS_W + DIR_W + SPEED_W + DEG_W + KMH_W;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CHECKSUM  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERSPEED = 2'd2;

  localparam logic [DEG_W-1:0] DEG_SCALE = 12'd225;
  localparam logic [KMH_W-1:0] KMH_SCALE = 18'd36;

  // Controller to datapath
  typedef struct packed {
    logic load_edge;  // capture the timestamp of the accepted word
    logic arm;        // start a new frame at this edge
    logic acc;        // add interval to elapsed sum, load the divider
    logic div_step;   // one restoring division step
    logic append;     // append quotient bits, toggle level
    logic pad;        // fill the rest of the frame with the current level
    logic emit;       // load the result register, clear the frame state
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic armed;
    logic in_time;    // interval keeps the elapsed sum within the timeout
    logic out_free;   // result register can take a new word
  } dp_status_t;

endpackage

// ===== hdl/wsfd_ctrl.sv =====
// Sequencer for the frame decoder: edge check, division steps, append, emit.
`timescale 1ns / 1ps

module wsfd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  wsfd_pkg::dp_status_t  status_i,
  output wsfd_pkg::ctrl_cmd_t   cmd_o
);

  localparam int CNT_W = $clog2(wsfd_pkg::DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wsfd_pkg::DIV_W - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_APPEND = 3'd3;
  localparam logic [2:0] ST_DECODE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_edge = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (!status_i.armed) begin
          cmd_o.arm = 1'b1;
          state_d   = ST_IDLE;
        end else if (status_i.in_time) begin
          cmd_o.acc = 1'b1;
          cnt_d     = '0;
          state_d   = ST_DIV;
        end else begin
          cmd_o.pad = 1'b1;
          state_d   = ST_DECODE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_DECODE: begin
        // hold until the result register is free
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/wsfd_datapath.sv =====
// Frame decoder datapath: config registers, interval sum, divider, frame, result.
`timescale 1ns / 1ps

module wsfd_datapath #(
  parameter int FRAME_BITS = wsfd_pkg::FRAME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wsfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wsfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [wsfd_pkg::EDGE_W-1:0]       edge_time_i,
  input  wsfd_pkg::ctrl_cmd_t               cmd_i,
  output wsfd_pkg::dp_status_t              status_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [wsfd_pkg::OUT_W-1:0]        m_data_o
);

  localparam int CW    = $clog2(FRAME_BITS + 1);
  localparam int DW    = wsfd_pkg::DIV_W;
  localparam int EW    = wsfd_pkg::EDGE_W;
  localparam int SW    = wsfd_pkg::SUM_W;
  localparam logic [CW-1:0] COUNT_FULL = CW'(FRAME_BITS);

  // Configuration
  logic [wsfd_pkg::BIT_TIME_W-1:0] bit_time_q;
  logic [wsfd_pkg::TIMEOUT_W-1:0]  timeout_q;
  logic [wsfd_pkg::SPEED_W-1:0]    speed_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_time_q    <= wsfd_pkg::BIT_TIME_RST;
      timeout_q     <= wsfd_pkg::TIMEOUT_RST;
      speed_limit_q <= wsfd_pkg::SPEED_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wsfd_pkg::CFG_BIT_TIME:    bit_time_q    <= cfg_data_i;
        wsfd_pkg::CFG_TIMEOUT:     timeout_q     <= cfg_data_i;
        wsfd_pkg::CFG_SPEED_LIMIT: speed_limit_q <= cfg_data_i[wsfd_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame state
  logic                  armed_q, armed_d;
  logic [EW-1:0]         now_q, now_d;
  logic [EW-1:0]         last_q, last_d;
  logic [SW-1:0]         sum_q, sum_d;
  logic [CW-1:0]         count_q, count_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic                  level_q, level_d;
  logic [DW-1:0]         quo_q, quo_d;
  logic [DW-1:0]         rem_q, rem_d;

  // Interval check
  logic [EW-1:0] delta;
  logic [EW:0]   total;
  assign delta = now_q - last_q;
  assign total = (EW+1)'(sum_q) + {1'b0, delta};

  // Division step
  logic [DW:0] trial;
  logic        fits;
  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, bit_time_q};

  // Append: clamp the run to the room left in the frame
  logic [DW-1:0]         n_bits;
  logic [DW:0]           room;
  logic [CW-1:0]         new_count;
  logic [FRAME_BITS-1:0] fill_mask;

  assign n_bits    = cmd_i.pad ? '1 : quo_q;
  assign room      = (DW+1)'(FRAME_BITS) - (DW+1)'(count_q);
  assign new_count = ({1'b0, n_bits} >= room) ? COUNT_FULL : count_q + CW'(n_bits);

  always_comb begin
    for (int i = 0; i < FRAME_BITS; i++) begin
      fill_mask[i] = (CW'(i) >= count_q) && (CW'(i) < new_count);
    end
  end

  always_comb begin
    armed_d = armed_q;
    now_d   = now_q;
    last_d  = last_q;
    sum_d   = sum_q;
    count_d = count_q;
    frame_d = frame_q;
    level_d = level_q;
    quo_d   = quo_q;
    rem_d   = rem_q;

    if (cmd_i.load_edge) begin
      now_d = edge_time_i;
    end
    if (cmd_i.arm) begin
      armed_d = 1'b1;
      last_d  = now_q;
      sum_d   = '0;
      count_d = '0;
      frame_d = '0;
      level_d = 1'b1;
    end
    if (cmd_i.acc) begin
      sum_d  = total[SW-1:0];
      last_d = now_q;
      quo_d  = delta[DW-1:0];
      rem_d  = '0;
    end
    if (cmd_i.div_step) begin
      quo_d = {quo_q[DW-2:0], fits};
      rem_d = fits ? DW'(trial - {1'b0, bit_time_q}) : trial[DW-1:0];
    end
    if (cmd_i.append || cmd_i.pad) begin
      count_d = new_count;
      frame_d = frame_q | (level_q ? fill_mask : '0);
    end
    if (cmd_i.append) begin
      level_d = ~level_q;
    end
    if (cmd_i.emit) begin
      armed_d = 1'b0;
      last_d  = '0;
      sum_d   = '0;
      count_d = '0;
      frame_d = '0;
      level_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      last_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
      frame_q <= '0;
      level_q <= 1'b1;
    end else begin
      armed_q <= armed_d;
      last_q  <= last_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      frame_q <= frame_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // Decode, all fields inverted on the line
  logic [wsfd_pkg::DIR_W-1:0]    dir;
  logic [wsfd_pkg::SPEED_W-1:0]  spd;
  logic [wsfd_pkg::CHK_W-1:0]    chk;
  logic [wsfd_pkg::CHK_W-1:0]    chk_sum;
  logic [wsfd_pkg::STATUS_W-1:0] status;
  logic [wsfd_pkg::DEG_W-1:0]    deg;
  logic [wsfd_pkg::KMH_W-1:0]    kmh;

  assign dir = ~frame_q[wsfd_pkg::DIR_LSB +: wsfd_pkg::DIR_W];
  assign spd = ~frame_q[wsfd_pkg::SPD_LSB +: wsfd_pkg::SPEED_W];
  assign chk = ~frame_q[wsfd_pkg::CHK_LSB +: wsfd_pkg::CHK_W];
  assign chk_sum = dir + spd[3:0] + spd[7:4] + spd[11:8];

  always_comb begin
    priority if (chk_sum != chk) begin
      status = wsfd_pkg::STATUS_CHECKSUM;
    end else if (spd >= speed_limit_q) begin
      status = wsfd_pkg::STATUS_OVERSPEED;
    end else begin
      status = wsfd_pkg::STATUS_OK;
    end
  end

  assign deg = wsfd_pkg::DEG_W'(dir) * wsfd_pkg::DEG_SCALE;
  assign kmh = wsfd_pkg::KMH_W'(spd) * wsfd_pkg::KMH_SCALE;

  // Result register
  logic                       m_valid_q, m_valid_d;
  logic [wsfd_pkg::OUT_W-1:0] out_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_i.emit) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= {kmh, deg, spd, dir, status};
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = out_q;

  assign status_o.armed    = armed_q;
  assign status_o.in_time  = total <= (EW+1)'(timeout_q);
  assign status_o.out_free = !m_valid_q || m_ready_i;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_FULL)
    else $error("frame bit count beyond frame length");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!m_valid_q || m_ready_i))
    else $error("result overwritten before it was taken");

  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (m_valid_q && !armed_q && count_q == '0))
    else $error("frame state not cleared after emit");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sum_q[SW-1])
    else $error("elapsed sum beyond timeout range");
`endif

endmodule

// ===== hdl/wind_sensor_frame_decoder.sv =====
// Top level of the wind sensor frame decoder: sequencer plus datapath.
`timescale 1ns / 1ps

// Usage
//   Input stream: each word is the 32-bit microsecond timestamp of a level
//   change on the sensor line. The first edge arms a frame; each later edge
//   appends interval / bit_time bits of the current level, then the level
//   toggles. An edge that pushes the elapsed time past frame_timeout_us is
//   dropped: it pads and closes the frame, and one result word follows.
//   Output stream: one 48-bit result word per closed frame.
//   Config port: write bit_time_us (0), frame_timeout_us (1), speed_limit (2)
//   while the block is idle; any other index is ignored.
// Steps per edge
//   Arming edge: capture, then arm; ready again after the arm.
//   Data edge: capture, timeout check, 16 restoring divide steps of
//   one shared divider, append; no new edge is taken until after the append.
//   Closing edge: capture, pad, emit once the result register is free; ready again then.
// Reset
//   Clears the frame, drops any pending result, restores register defaults.
// Stall
//   A held result does not block new edges; only a second closing edge waits
//   until the result register drains.

module wind_sensor_frame_decoder #(
  parameter int FRAME_BITS = wsfd_pkg::FRAME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic [wsfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wsfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Edge words
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [wsfd_pkg::EDGE_W-1:0]       s_axis_tdata_i,  // [31:0] edge_time
  // Result words
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [1:0] status, [5:2] wind_direction, [17:6] wind_speed_raw,
  // [29:18] direction_deg_x10, [47:30] speed_kmh_x100
  output logic [wsfd_pkg::OUT_W-1:0]        m_axis_tdata_o
);

  wsfd_pkg::ctrl_cmd_t  cmd;
  wsfd_pkg::dp_status_t status;

  // Sequence each accepted edge through check, divide and append
  wsfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the frame, divider, decode and result register
  wsfd_datapath #(
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .edge_time_i (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o)
  );

endmodule

// ===== tb/tb_wind_sensor_frame_decoder.sv =====
// Self-checking testbench for the wind sensor frame decoder: edge stimulus, frame model, checks.
`timescale 1ns / 1ps

module tb_wind_sensor_frame_decoder;
  import wsfd_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int NFRAME         = FRAME_BITS_DEF;
  localparam int ITEM_TARGET    = 900;
  localparam int CALM_TAIL      = 150;   // last words of the run go without idling
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 2500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_FRAMES   = 6;

  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // One result word, laid out as on m_axis_tdata_o (status in the lowest bits).
  typedef struct packed {
    logic [KMH_W-1:0]    kmh;
    logic [DEG_W-1:0]    deg;
    logic [SPEED_W-1:0]  speed;
    logic [DIR_W-1:0]    dir;
    logic [STATUS_W-1:0] status;
  } wind_report_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [EDGE_W-1:0]     s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata_o;

  wind_sensor_frame_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame model: register copies and frame state, as after reset.
  // ---------------------------------------------------------------------------
  logic [BIT_TIME_W-1:0] bit_time_us = BIT_TIME_RST;
  logic [TIMEOUT_W-1:0]  timeout_us  = TIMEOUT_RST;
  logic [SPEED_W-1:0]    speed_limit = SPEED_LIMIT_RST;

  bit                    frame_armed = 1'b0;
  logic [EDGE_W-1:0]     prev_edge   = '0;
  logic [SUM_W-1:0]      elapsed_us  = '0;
  int                    frame_len   = 0;
  logic [NFRAME-1:0]     frame_word  = '0;
  bit                    level       = 1'b1;

  wind_report_t          pending_reports[$];

  int errors        = 0;
  int edges_sent    = 0;
  int reports_due   = 0;
  int reports_seen  = 0;
  int config_count  = 0;
  bit bursty        = 1'b1;
  bit hold_req      = 1'b0;

  // Append n bits of the current level; drop whatever no longer fits.
  function automatic void fill_frame(input longint unsigned n);
    while (n > 0 && frame_len < NFRAME) begin
      frame_word[frame_len] = level;
      frame_len++;
      n--;
    end
  endfunction

  // Decode the inverted fields of the finished frame and grade it.
  function automatic wind_report_t decode_frame();
    wind_report_t  r;
    logic [CHK_W-1:0] chk;
    logic [CHK_W-1:0] sum;
    r.dir   = ~frame_word[DIR_LSB +: DIR_W];
    r.speed = ~frame_word[SPD_LSB +: SPEED_W];
    chk     = ~frame_word[CHK_LSB +: CHK_W];
    sum     = r.dir + r.speed[3:0] + r.speed[7:4] + r.speed[11:8];
    // checksum outranks the speed test when both are wrong
    if (sum != chk)
      r.status = STATUS_CHECKSUM;
    else if (r.speed >= speed_limit)
      r.status = STATUS_OVERSPEED;
    else
      r.status = STATUS_OK;
    r.deg = DEG_W'(int'(r.dir) * 225);
    r.kmh = KMH_W'(int'(r.speed) * 36);
    return r;
  endfunction

  // Advance the frame model by one accepted edge word.
  function automatic void track_edge(input logic [EDGE_W-1:0] t);
    logic [EDGE_W-1:0] delta;
    logic [63:0]       reach;
    longint unsigned   n;
    if (!frame_armed) begin
      frame_armed = 1'b1;
      prev_edge   = t;
      elapsed_us  = '0;
      frame_len   = 0;
      frame_word  = '0;
      level       = 1'b1;
    end else begin
      delta = t - prev_edge;
      reach = 64'(elapsed_us) + 64'(delta);
      if (reach <= 64'(timeout_us)) begin
        // a zero bit time means the interval fills the rest of the frame
        n = (bit_time_us == '0) ? '1 : longint'(delta / bit_time_us);
        elapsed_us = elapsed_us + delta[SUM_W-1:0];
        prev_edge  = t;
        fill_frame(n);
        level = ~level;
      end else begin
        // past the timeout: drop the edge, pad, report, go idle
        fill_frame('1);
        pending_reports.push_back(decode_frame());
        reports_due++;
        frame_armed = 1'b0;
        prev_edge   = '0;
        elapsed_us  = '0;
        frame_len   = 0;
        frame_word  = '0;
        level       = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks. Every task starts and ends right after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one edge word, hold it until accepted, then maybe idle a burst.
  task automatic send_edge(input logic [EDGE_W-1:0] t);
    int gap;
    s_axis_tdata_i  <= t;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_edge(t);
    edges_sent++;
    if (bursty && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write all registers in consecutive cycles, then poke the spare index.
  task automatic set_config(input logic [BIT_TIME_W-1:0] bt,
                            input logic [TIMEOUT_W-1:0]  to,
                            input logic [SPEED_W-1:0]    lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BIT_TIME;
    cfg_data_i <= bt;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TIMEOUT;
    cfg_data_i <= to;
    @(posedge clk_i);
    // upper data bits are junk here and must be masked off
    cfg_idx_i  <= CFG_SPEED_LIMIT;
    cfg_data_i <= {4'($urandom_range(0, 15)), lim};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPARE;
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    bit_time_us  = bt;
    timeout_us   = to;
    speed_limit  = lim;
    config_count++;
  endtask

  // Stop offering, wait for every expected report, then let the block settle.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Line bits for a frame carrying the given fields, start and tail random.
  function automatic logic [NFRAME-1:0] make_line(input logic [DIR_W-1:0] dir,
                                                  input logic [SPEED_W-1:0] spd,
                                                  input bit chk_ok);
    logic [NFRAME-1:0] line;
    logic [CHK_W-1:0]  chk;
    chk = dir + spd[3:0] + spd[7:4] + spd[11:8];
    if (!chk_ok) chk = chk ^ CHK_W'($urandom_range(1, 15));
    line = NFRAME'({$urandom, $urandom});
    line[DIR_LSB +: DIR_W]   = ~dir;
    line[SPD_LSB +: SPEED_W] = ~spd;
    line[CHK_LSB +: CHK_W]   = ~chk;
    return line;
  endfunction

  // An interval that surely runs past the timeout.
  function automatic logic [EDGE_W-1:0] close_gap();
    if ($urandom_range(0, 7) == 0)
      return $urandom | 32'h0001_0000;
    return timeout_us + 1 + $urandom_range(0, 5000);
  endfunction

  // Arm, encode the first enc_len line bits as runs with jitter, then close.
  task automatic send_frame(input logic [NFRAME-1:0] line, input int enc_len,
                            input logic [EDGE_W-1:0] gap_to_close);
    logic [EDGE_W-1:0] t;
    bit                lvl;
    int                pos;
    int                run;
    int                jmax;
    t    = $urandom;
    lvl  = 1'b1;
    pos  = 0;
    jmax = bit_time_us / 16;
    send_edge(t);
    while (pos < enc_len) begin
      run = 0;
      while (pos + run < enc_len && line[pos + run] == lvl) run++;
      // a run of zero bits is a short interval that only toggles the level
      t = t + run * bit_time_us + $urandom_range(0, jmax);
      send_edge(t);
      pos += run;
      lvl = ~lvl;
    end
    send_edge(t + gap_to_close);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: all-ones fields (both errors) and all-zero decode (ok).
  task automatic test_field_extremes();
    send_frame({{(NFRAME - 5){1'b0}}, 5'b11111}, NFRAME, close_gap());
    send_frame('1, NFRAME, close_gap());
    wait_idle();
  endtask

  // Limit of zero turns a clean zero-speed frame into overspeed.
  task automatic test_speed_limit_floor();
    set_config(BIT_TIME_RST, TIMEOUT_RST, '0);
    send_frame('1, NFRAME, close_gap());
    wait_idle();
  endtask

  // Zero bit time: one interval fills the whole frame.
  task automatic test_zero_bit_time();
    logic [EDGE_W-1:0] t;
    set_config('0, TIMEOUT_RST, SPEED_LIMIT_RST);
    t = $urandom;
    send_edge(t);
    send_edge(t + 100);
    send_edge(t + 100 + TIMEOUT_RST);
    wait_idle();
  endtask

  // Largest registers, an interval exactly at the timeout across the
  // timestamp wrap, then one more microsecond to close.
  task automatic test_wide_timing();
    set_config('1, '1, '1);
    send_edge(32'hFFFF_8000);
    send_edge(32'h0000_7FFF);
    send_edge(32'h0000_8000);
    wait_idle();
  endtask

  // Smallest nonzero bit time and timeout.
  task automatic test_narrow_timing();
    logic [EDGE_W-1:0] t;
    set_config(16'd1, 16'd1, '0);
    t = $urandom;
    send_edge(t);
    send_edge(t + 1);
    send_edge(t + 3);
    wait_idle();
  endtask

  // A huge bit count saturates the frame.
  task automatic test_frame_saturation();
    logic [EDGE_W-1:0] t;
    set_config(16'd1, 16'd60000, '1);
    t = $urandom;
    send_edge(t);
    send_edge(t + 50000);
    send_edge(t + 70000);
    wait_idle();
  endtask

  // Hold the result side off for a long stretch while frames keep coming,
  // so a second closing edge backs up into the input.
  task automatic test_backpressure();
    set_config(BIT_TIME_RST, TIMEOUT_RST, 12'd2000);
    hold_req <= 1'b1;
    repeat (3)
      send_frame(make_line(DIR_W'($urandom), SPEED_W'($urandom), 1'b1),
                 $urandom_range(25, NFRAME), close_gap());
    wait_idle();
  endtask

  // Random settings; mostly well-formed frames, some broken ones and noise.
  task automatic test_random_traffic();
    int                    frame_no;
    int                    kind;
    logic [BIT_TIME_W-1:0] bt;
    int                    to;
    logic [EDGE_W-1:0]     noise_t;
    frame_no = 0;
    noise_t  = $urandom;
    while (edges_sent < ITEM_TARGET) begin
      if (frame_no % PHASE_FRAMES == 0) begin
        wait_idle();
        bt = (frame_no % (4 * PHASE_FRAMES) == 0) ? $urandom_range(1, 8)
                                                  : $urandom_range(1, 1400);
        to = 43 * bt + $urandom_range(0, bt);
        if (to > 65535) to = 65535;
        if ($urandom_range(0, 4) == 0) to = $urandom_range(1, 65535);
        set_config(bt, TIMEOUT_W'(to), SPEED_W'($urandom_range(0, 4095)));
      end
      if (edges_sent >= ITEM_TARGET - CALM_TAIL) bursty <= 1'b0;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // stray edges: small steps or jumps anywhere on the time line
        repeat ($urandom_range(1, 4)) begin
          noise_t = $urandom_range(0, 1) ? $urandom
                                         : noise_t + $urandom_range(0, 3 * bit_time_us);
          send_edge(noise_t);
        end
      end else if (kind == 1) begin
        // truncated frame: close early and let padding fill the fields
        send_frame(make_line(DIR_W'($urandom), SPEED_W'($urandom), $urandom_range(0, 1)),
                   $urandom_range(0, 24), close_gap());
      end else begin
        send_frame(make_line(DIR_W'($urandom), SPEED_W'($urandom), $urandom_range(0, 3) != 0),
                   $urandom_range(25, NFRAME), close_gap());
      end
      frame_no++;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req <= 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (bursty && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expected report.
  always @(posedge clk_i) begin
    wind_report_t got;
    wind_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.dir !== want.dir) begin
          $error("wind_direction: expected %0d, got %0d", want.dir, got.dir);
          errors++;
        end
        if (got.speed !== want.speed) begin
          $error("wind_speed_raw: expected %0d, got %0d", want.speed, got.speed);
          errors++;
        end
        if (got.deg !== want.deg) begin
          $error("direction_deg_x10: expected %0d, got %0d", want.deg, got.deg);
          errors++;
        end
        if (got.kmh !== want.kmh) begin
          $error("speed_kmh_x100: expected %0d, got %0d", want.kmh, got.kmh);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no word accepted for %0d cycles, %0d reports outstanding",
             quiet_cycles, pending_reports.size());
      $display("FAIL wind_sensor_frame_decoder");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_speed_limit_floor();
    test_zero_bit_time();
    test_wide_timing();
    test_narrow_timing();
    test_frame_saturation();
    test_backpressure();
    test_random_traffic();

    $display("Sent %0d edge words over %0d register settings; checked %0d frame reports",
             edges_sent, config_count, reports_seen);
    $display("incl. timestamp wrap, zero and one-us bit time, frame saturation, long stall");
    if (errors == 0)
      $display("PASS wind_sensor_frame_decoder");
    else
      $display("FAIL wind_sensor_frame_decoder");
    $finish;
  end

endmodule
